// ----- design/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ----- design/ofs_pkg.sv -----
package ofs_pkg;

    // default fraction bits of the quotients and of u, v
    localparam int FRAC_BITS_DEF = 16;
    // fraction bits of oct_u and oct_v on the result port
    localparam int OUT_FRAC = 16;

    localparam int DIR_W  = 16;
    localparam int MAG_W  = 16;
    localparam int SUM_W  = 17;
    localparam int FM_W   = 6;
    localparam int UNIT_W = 17;
    localparam int COL_W  = 6;
    localparam int NB_W   = 7;

    localparam logic [FM_W-1:0] FM_RESET = 6'd15;

    // input beat
    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
    } dir_t;

    // result beat
    typedef struct packed {
        logic [UNIT_W-1:0] oct_u;
        logic [UNIT_W-1:0] oct_v;
        logic [COL_W-1:0]  base_col;
        logic [COL_W-1:0]  base_row;
        logic [NB_W-1:0]   mid_col;
        logic [NB_W-1:0]   mid_row;
        logic [NB_W-1:0]   far_col;
        logic [NB_W-1:0]   far_row;
        logic              upper_triangle;
        logic              zero_vector;
    } res_t;

    // per-item flags that ride along the pipeline
    typedef struct packed {
        logic zero;
        logic fold;
        logic neg_x;
        logic neg_z;
    } side_t;

endpackage

// ----- design/ofs_prep.sv -----
module ofs_prep #(
    parameter int FRAC_BITS = ofs_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  ofs_pkg::dir_t              dir,
    output logic                       out_valid,
    output ofs_pkg::side_t             side,
    output logic [ofs_pkg::SUM_W-1:0]  sum,
    output logic [ofs_pkg::SUM_W-1:0]  rem_x,
    output logic [ofs_pkg::SUM_W-1:0]  rem_z,
    output logic [FRAC_BITS:0]         quo_x,
    output logic [FRAC_BITS:0]         quo_z
);

    localparam int QW = FRAC_BITS + 1;

    logic [ofs_pkg::MAG_W-1:0] mag_x, mag_y, mag_z;
    logic                      x_zero, y_zero, z_zero;
    logic                      top_x, top_z;

    logic                       valid_reg;
    ofs_pkg::side_t             side_reg, side_next;
    logic [ofs_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [ofs_pkg::SUM_W-1:0]  rem_x_reg, rem_x_next;
    logic [ofs_pkg::SUM_W-1:0]  rem_z_reg, rem_z_next;
    logic [QW-1:0]              quo_x_reg, quo_x_next;
    logic [QW-1:0]              quo_z_reg, quo_z_next;

    // magnitudes, l1 norm and the integer quotient bit
    always_comb
    begin
        mag_x  = dir.dir_x[ofs_pkg::DIR_W-1] ? ofs_pkg::MAG_W'(~dir.dir_x + 16'sd1) : dir.dir_x;
        mag_y  = dir.dir_y[ofs_pkg::DIR_W-1] ? ofs_pkg::MAG_W'(~dir.dir_y + 16'sd1) : dir.dir_y;
        mag_z  = dir.dir_z[ofs_pkg::DIR_W-1] ? ofs_pkg::MAG_W'(~dir.dir_z + 16'sd1) : dir.dir_z;
        x_zero = (dir.dir_x == '0);
        y_zero = (dir.dir_y == '0);
        z_zero = (dir.dir_z == '0);

        // quotient reaches one only when the other two components are zero
        top_x = y_zero && z_zero && !x_zero;
        top_z = x_zero && y_zero && !z_zero;

        sum_next = ofs_pkg::SUM_W'(mag_x) + ofs_pkg::SUM_W'(mag_y)
                 + ofs_pkg::SUM_W'(mag_z);
        rem_x_next = top_x ? '0 : ofs_pkg::SUM_W'(mag_x);
        rem_z_next = top_z ? '0 : ofs_pkg::SUM_W'(mag_z);
        quo_x_next = QW'(top_x);
        quo_z_next = QW'(top_z);

        side_next.zero  = x_zero && y_zero && z_zero;
        side_next.fold  = dir.dir_y[ofs_pkg::DIR_W-1] || y_zero;
        side_next.neg_x = dir.dir_x[ofs_pkg::DIR_W-1];
        side_next.neg_z = dir.dir_z[ofs_pkg::DIR_W-1];
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        side_reg  <= side_next;
        sum_reg   <= sum_next;
        rem_x_reg <= rem_x_next;
        rem_z_reg <= rem_z_next;
        quo_x_reg <= quo_x_next;
        quo_z_reg <= quo_z_next;
    end

    assign out_valid = valid_reg;
    assign side      = side_reg;
    assign sum       = sum_reg;
    assign rem_x     = rem_x_reg;
    assign rem_z     = rem_z_reg;
    assign quo_x     = quo_x_reg;
    assign quo_z     = quo_z_reg;

endmodule

// ----- design/ofs_div_step.sv -----
module ofs_div_step #(
    parameter int FRAC_BITS = ofs_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  ofs_pkg::side_t             in_side,
    input  logic [ofs_pkg::SUM_W-1:0]  in_sum,
    input  logic [ofs_pkg::SUM_W-1:0]  in_rem_x,
    input  logic [ofs_pkg::SUM_W-1:0]  in_rem_z,
    input  logic [FRAC_BITS:0]         in_quo_x,
    input  logic [FRAC_BITS:0]         in_quo_z,
    output logic                       out_valid,
    output ofs_pkg::side_t             out_side,
    output logic [ofs_pkg::SUM_W-1:0]  out_sum,
    output logic [ofs_pkg::SUM_W-1:0]  out_rem_x,
    output logic [ofs_pkg::SUM_W-1:0]  out_rem_z,
    output logic [FRAC_BITS:0]         out_quo_x,
    output logic [FRAC_BITS:0]         out_quo_z
);

    localparam int QW = FRAC_BITS + 1;
    localparam int CW = ofs_pkg::SUM_W + 1;

    logic [CW-1:0] cand_x, cand_z, div_ext, diff_x, diff_z;
    logic          ge_x, ge_z;

    logic                       valid_reg;
    ofs_pkg::side_t             side_reg;
    logic [ofs_pkg::SUM_W-1:0]  sum_reg;
    logic [ofs_pkg::SUM_W-1:0]  rem_x_reg, rem_x_next;
    logic [ofs_pkg::SUM_W-1:0]  rem_z_reg, rem_z_next;
    logic [QW-1:0]              quo_x_reg, quo_x_next;
    logic [QW-1:0]              quo_z_reg, quo_z_next;

    // one restoring step for both quotients
    always_comb
    begin
        div_ext = {1'b0, in_sum};
        cand_x  = {in_rem_x, 1'b0};
        cand_z  = {in_rem_z, 1'b0};
        diff_x  = cand_x - div_ext;
        diff_z  = cand_z - div_ext;
        ge_x    = (cand_x >= div_ext);
        ge_z    = (cand_z >= div_ext);

        rem_x_next = ge_x ? diff_x[ofs_pkg::SUM_W-1:0] : cand_x[ofs_pkg::SUM_W-1:0];
        rem_z_next = ge_z ? diff_z[ofs_pkg::SUM_W-1:0] : cand_z[ofs_pkg::SUM_W-1:0];
        quo_x_next = {in_quo_x[QW-2:0], ge_x};
        quo_z_next = {in_quo_z[QW-2:0], ge_z};
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        side_reg  <= in_side;
        sum_reg   <= in_sum;
        rem_x_reg <= rem_x_next;
        rem_z_reg <= rem_z_next;
        quo_x_reg <= quo_x_next;
        quo_z_reg <= quo_z_next;
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_sum   = sum_reg;
    assign out_rem_x = rem_x_reg;
    assign out_rem_z = rem_z_reg;
    assign out_quo_x = quo_x_reg;
    assign out_quo_z = quo_z_reg;

endmodule

// ----- design/ofs_grid.sv -----
module ofs_grid #(
    parameter int FRAC_BITS = ofs_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  ofs_pkg::side_t            side,
    input  logic [FRAC_BITS:0]        quo_x,
    input  logic [FRAC_BITS:0]        quo_z,
    input  logic [ofs_pkg::FM_W-1:0]  frames_minus_one,
    output logic                      out_valid,
    output ofs_pkg::res_t             result
);

    localparam int QW  = FRAC_BITS + 1;
    localparam int TW  = FRAC_BITS + 2;
    localparam int GW  = QW + ofs_pkg::FM_W;
    localparam int SHR = (FRAC_BITS >= ofs_pkg::OUT_FRAC) ? FRAC_BITS - ofs_pkg::OUT_FRAC : 0;
    localparam int SHL = (FRAC_BITS <  ofs_pkg::OUT_FRAC) ? ofs_pkg::OUT_FRAC - FRAC_BITS : 0;
    localparam int EW  = QW + ofs_pkg::OUT_FRAC;
    localparam logic [TW-1:0] ONE = {2'b01, {FRAC_BITS{1'b0}}};

    logic [TW-1:0] mag_x, mag_z, t_x, t_z;
    logic [QW-1:0] u_next, v_next;

    logic [GW-1:0]              gu, gv;
    logic [FRAC_BITS-1:0]       frac_u, frac_v;
    logic [ofs_pkg::COL_W-1:0]  col, row;
    logic                       up;
    logic [EW-1:0]              u_ext, v_ext;
    ofs_pkg::res_t              res_next;

    logic           va_reg, vb_reg, done_reg;
    logic           zero_a_reg, zero_b_reg;
    logic [QW-1:0]  u_a_reg, v_a_reg, u_b_reg, v_b_reg;
    logic [GW-1:0]  gu_reg, gv_reg;
    ofs_pkg::res_t  result_reg;

    // fold the lower hemisphere and map to [0,1]; the sign stays that of the input
    always_comb
    begin
        mag_x  = side.fold ? ONE - TW'(quo_z) : TW'(quo_x);
        mag_z  = side.fold ? ONE - TW'(quo_x) : TW'(quo_z);
        t_x    = side.neg_x ? ONE - mag_x : ONE + mag_x;
        t_z    = side.neg_z ? ONE - mag_z : ONE + mag_z;
        u_next = t_x[TW-1:1];
        v_next = t_z[TW-1:1];
    end

    // scale by the frame count
    always_comb
    begin
        gu = GW'(u_a_reg) * GW'(frames_minus_one);
        gv = GW'(v_a_reg) * GW'(frames_minus_one);
    end

    // grid cell, triangle and frames
    always_comb
    begin
        frac_u = gu_reg[FRAC_BITS-1:0];
        frac_v = gv_reg[FRAC_BITS-1:0];
        col    = gu_reg[FRAC_BITS +: ofs_pkg::COL_W];
        row    = gv_reg[FRAC_BITS +: ofs_pkg::COL_W];
        up     = (frac_u > frac_v);
        u_ext  = EW'(u_b_reg);
        v_ext  = EW'(v_b_reg);

        res_next                = '0;
        if (zero_b_reg)
        begin
            res_next.zero_vector = 1'b1;
        end
        else
        begin
            res_next.oct_u          = ofs_pkg::UNIT_W'((u_ext << SHL) >> SHR);
            res_next.oct_v          = ofs_pkg::UNIT_W'((v_ext << SHL) >> SHR);
            res_next.base_col       = col;
            res_next.base_row       = row;
            res_next.mid_col        = ofs_pkg::NB_W'(col) + ofs_pkg::NB_W'(up);
            res_next.mid_row        = ofs_pkg::NB_W'(row) + ofs_pkg::NB_W'(!up);
            res_next.far_col        = ofs_pkg::NB_W'(col) + 7'd1;
            res_next.far_row        = ofs_pkg::NB_W'(row) + 7'd1;
            res_next.upper_triangle = up;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= in_valid;
            vb_reg   <= va_reg;
            done_reg <= vb_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        zero_a_reg <= side.zero;
        u_a_reg    <= u_next;
        v_a_reg    <= v_next;
        zero_b_reg <= zero_a_reg;
        u_b_reg    <= u_a_reg;
        v_b_reg    <= v_a_reg;
        gu_reg     <= gu;
        gv_reg     <= gv;
        result_reg <= res_next;
    end

    assign out_valid = done_reg;
    assign result    = result_reg;

endmodule

// ----- design/octahedral_frame_select.sv -----
// channel  | signals                   | beat moves when
// ---------+---------------------------+-----------------------------
// command  | start, busy, dir          | start high and busy low
// result   | done, result              | done high (one cycle)
// config   | cfg_wr_en, cfg_wr_data    | cfg_wr_en high
//
// one beat per cycle; busy stays low, a command is taken every cycle.
// the pipeline has one input stage, one divider stage per quotient
// fraction bit, then fold, scale and output stages.
// reset clears the valid bits only and loads frames_minus_one with 15.
// the receiver cannot stall; done is a one-cycle strobe.
module octahedral_frame_select #(
    parameter int FRAC_BITS = ofs_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  ofs_pkg::dir_t             dir,
    input  logic                      cfg_wr_en,
    input  logic [ofs_pkg::FM_W-1:0]  cfg_wr_data,
    output logic                      done,
    output ofs_pkg::res_t             result
);

    localparam int QW = FRAC_BITS + 1;

    logic [ofs_pkg::FM_W-1:0] fm_reg;

    logic                       valid_c [0:FRAC_BITS];
    ofs_pkg::side_t             side_c  [0:FRAC_BITS];
    logic [ofs_pkg::SUM_W-1:0]  sum_c   [0:FRAC_BITS];
    logic [ofs_pkg::SUM_W-1:0]  rem_x_c [0:FRAC_BITS];
    logic [ofs_pkg::SUM_W-1:0]  rem_z_c [0:FRAC_BITS];
    logic [QW-1:0]              quo_x_c [0:FRAC_BITS];
    logic [QW-1:0]              quo_z_c [0:FRAC_BITS];

    // frame count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fm_reg <= ofs_pkg::FM_RESET;
        end
        else if (cfg_wr_en)
        begin
            fm_reg <= cfg_wr_data;
        end
    end

    assign busy = 1'b0;

    // magnitudes and l1 norm
    ofs_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .dir       (dir),
        .out_valid (valid_c[0]),
        .side      (side_c[0]),
        .sum       (sum_c[0]),
        .rem_x     (rem_x_c[0]),
        .rem_z     (rem_z_c[0]),
        .quo_x     (quo_x_c[0]),
        .quo_z     (quo_z_c[0])
    );

    // pipelined divider, one fraction bit per stage
    for (genvar k = 0; k < FRAC_BITS; k++)
    begin : g_div
        ofs_div_step #(
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[k]),
            .in_side   (side_c[k]),
            .in_sum    (sum_c[k]),
            .in_rem_x  (rem_x_c[k]),
            .in_rem_z  (rem_z_c[k]),
            .in_quo_x  (quo_x_c[k]),
            .in_quo_z  (quo_z_c[k]),
            .out_valid (valid_c[k+1]),
            .out_side  (side_c[k+1]),
            .out_sum   (sum_c[k+1]),
            .out_rem_x (rem_x_c[k+1]),
            .out_rem_z (rem_z_c[k+1]),
            .out_quo_x (quo_x_c[k+1]),
            .out_quo_z (quo_z_c[k+1])
        );
    end

    // fold, scale and frame selection
    ofs_grid #(
        .FRAC_BITS (FRAC_BITS)
    ) u_grid (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (valid_c[FRAC_BITS]),
        .side             (side_c[FRAC_BITS]),
        .quo_x            (quo_x_c[FRAC_BITS]),
        .quo_z            (quo_z_c[FRAC_BITS]),
        .frames_minus_one (fm_reg),
        .out_valid        (done),
        .result           (result)
    );

endmodule

// ----- design/ofs_checker.sv -----
`include "assert_macros.svh"

module ofs_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           busy,
    input  logic           done,
    input  ofs_pkg::res_t  result
);

    // zero vector gives an all-zero beat
    `ASSERT_CLK(a_zero_clears, done && result.zero_vector |-> result.oct_u == '0 && result.oct_v == '0 && result.base_col == '0 && result.base_row == '0 && result.mid_col == '0 && result.mid_row == '0 && result.far_col == '0 && result.far_row == '0 && !result.upper_triangle, "zero vector beat not cleared")

    // middle frame follows the triangle choice
    `ASSERT_CLK(a_mid_pick, done && !result.zero_vector |-> (result.upper_triangle && result.mid_col == {1'b0, result.base_col} + 7'd1 && result.mid_row == {1'b0, result.base_row}) || (!result.upper_triangle && result.mid_col == {1'b0, result.base_col} && result.mid_row == {1'b0, result.base_row} + 7'd1), "middle frame wrong")

    // far frame is the diagonal neighbor
    `ASSERT_CLK(a_far_frame, done && !result.zero_vector |-> result.far_col == {1'b0, result.base_col} + 7'd1 && result.far_row == {1'b0, result.base_row} + 7'd1, "far frame wrong")

    // octahedral coordinates stay within [0,1]
    `ASSERT_CLK(a_unit_range, done |-> result.oct_u <= 17'h10000 && result.oct_v <= 17'h10000, "oct coordinate above one")

    // fully pipelined: commands are never held off
    `ASSERT_NEVER(a_never_busy, busy, "busy raised")

endmodule

bind octahedral_frame_select ofs_checker u_ofs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (busy),
    .done   (done),
    .result (result)
);
